// ----- hw/rtl/pfd_pkg.sv -----
// shared types and constants for the playfair digraph decipher unit
// no dependencies; imported by playfair_digraph_decipher_unit

package pfd_pkg;

  localparam int SQ_DIM   = 5;
  localparam int SQ_CELLS = SQ_DIM * SQ_DIM;
  localparam int LETTER_W = 5;
  localparam int KEY_W    = SQ_DIM * LETTER_W;
  localparam int IDX_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef logic [LETTER_W-1:0]  letter_t;
  typedef logic [KEY_W-1:0]     key_row_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [SQ_CELLS-1:0]  match_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam letter_t CODE_I = letter_t'(8);
  localparam letter_t CODE_J = letter_t'(9);

  // configuration register indexes
  localparam cfg_idx_t REG_KEY_ROW_0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_ROW_1 = cfg_idx_t'(1);
  localparam cfg_idx_t REG_KEY_ROW_2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_KEY_ROW_3 = cfg_idx_t'(3);
  localparam cfg_idx_t REG_KEY_ROW_4 = cfg_idx_t'(4);

  // stage 1: cell match vectors, bit r*SQ_DIM+c
  typedef struct packed {
    match_t match_a;
    match_t match_b;
    logic   eot;
  } s1_t;

  // stage 2: first-match positions
  typedef struct packed {
    idx_t ar;
    idx_t ac;
    idx_t br;
    idx_t bc;
    logic found;
    logic eot;
  } s2_t;

  // stage 3: source cells of the plaintext letters
  typedef struct packed {
    idx_t pa_row;
    idx_t pa_col;
    idx_t pb_row;
    idx_t pb_col;
    logic found;
    logic eot;
  } s3_t;

endpackage

// ----- hw/rtl/playfair_digraph_decipher_unit.sv -----
// playfair digraph decipher unit, four-stage pipeline
// depends on pfd_pkg (types, constants, register indexes)
//
// usage
//   config: write key rows 0..4 through cfg_we / cfg_index / cfg_data, one
//   word per cycle, only while no digraph is in flight. each row packs five
//   5-bit letter codes, column k at bits 5k+4..5k. indexes above 4 are ignored.
//   input: a digraph word is taken at each rising edge with start high and
//   busy low. busy is always low, so one digraph can enter every cycle.
//   output: out_strobe marks one cycle holding plain_a, plain_b, not_found
//   and the end-of-text copy. the receiver takes it that cycle, no stall.
//   pipeline: a word passes through the four register stages in order
//   (match, priority encode, rule, cell read). throughput: one digraph per
//   cycle, since no stage ever holds its word.
//   reset: rst_n low clears the key rows to zero and all stage valid bits,
//   so no strobe comes out for words taken before or during reset.
//   a letter absent from the square sets not_found and zeroes both letters.
//   an input J is treated as I before the search.

module playfair_digraph_decipher_unit
  import pfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // configuration
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  key_row_t cfg_data,
  // input words
  input  logic     start,
  output logic     busy,
  input  letter_t  in_letter_a,
  input  letter_t  in_letter_b,
  input  logic     in_end_of_text,
  // result words
  output logic     out_strobe,
  output letter_t  out_plain_a,
  output letter_t  out_plain_b,
  output logic     out_not_found,
  output logic     out_end_of_text_out
);

  key_row_t key_r [SQ_DIM];

  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  letter_t pa_r, pa_nxt, pb_r, pb_nxt;
  logic nf_r, eot_r;

  // pipeline never blocks
  assign busy = 1'b0;

  // read one cell of the key square
  function automatic letter_t cell_at(input idx_t row, input idx_t col);
    key_row_t rw;
    letter_t  cv;
    begin
      rw = '0;
      cv = '0;
      case (row)
        3'd0:    rw = key_r[0];
        3'd1:    rw = key_r[1];
        3'd2:    rw = key_r[2];
        3'd3:    rw = key_r[3];
        3'd4:    rw = key_r[4];
        default: rw = '0;
      endcase
      case (col)
        3'd0:    cv = rw[0*LETTER_W +: LETTER_W];
        3'd1:    cv = rw[1*LETTER_W +: LETTER_W];
        3'd2:    cv = rw[2*LETTER_W +: LETTER_W];
        3'd3:    cv = rw[3*LETTER_W +: LETTER_W];
        3'd4:    cv = rw[4*LETTER_W +: LETTER_W];
        default: cv = '0;
      endcase
      return cv;
    end
  endfunction

  // one step back with wrap
  function automatic idx_t dec_wrap(input idx_t x);
    return (x == '0) ? idx_t'(SQ_DIM - 1) : idx_t'(x - idx_t'(1));
  endfunction

  // key square registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SQ_DIM; r++) key_r[r] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_ROW_0: key_r[0] <= cfg_data;
        REG_KEY_ROW_1: key_r[1] <= cfg_data;
        REG_KEY_ROW_2: key_r[2] <= cfg_data;
        REG_KEY_ROW_3: key_r[3] <= cfg_data;
        REG_KEY_ROW_4: key_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: fold J into I, compare against every cell
  always_comb begin
    letter_t a_m, b_m;
    a_m = (in_letter_a == CODE_J) ? CODE_I : in_letter_a;
    b_m = (in_letter_b == CODE_J) ? CODE_I : in_letter_b;
    s1_nxt.eot = in_end_of_text;
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int c = 0; c < SQ_DIM; c++) begin
        s1_nxt.match_a[r*SQ_DIM + c] = (key_r[r][c*LETTER_W +: LETTER_W] == a_m);
        s1_nxt.match_b[r*SQ_DIM + c] = (key_r[r][c*LETTER_W +: LETTER_W] == b_m);
      end
    end
  end

  // stage 2: first match in scan order wins, so scan backwards
  always_comb begin
    s2_nxt.ar = '0;
    s2_nxt.ac = '0;
    s2_nxt.br = '0;
    s2_nxt.bc = '0;
    for (int r = SQ_DIM - 1; r >= 0; r--) begin
      for (int c = SQ_DIM - 1; c >= 0; c--) begin
        if (s1_r.match_a[r*SQ_DIM + c]) begin
          s2_nxt.ar = idx_t'(r);
          s2_nxt.ac = idx_t'(c);
        end
        if (s1_r.match_b[r*SQ_DIM + c]) begin
          s2_nxt.br = idx_t'(r);
          s2_nxt.bc = idx_t'(c);
        end
      end
    end
    s2_nxt.found = (|s1_r.match_a) & (|s1_r.match_b);
    s2_nxt.eot   = s1_r.eot;
  end

  // stage 3: same row, same column or rectangle
  always_comb begin
    s3_nxt.found = s2_r.found;
    s3_nxt.eot   = s2_r.eot;
    if (s2_r.ar == s2_r.br) begin
      s3_nxt.pa_row = s2_r.ar;
      s3_nxt.pa_col = dec_wrap(s2_r.ac);
      s3_nxt.pb_row = s2_r.br;
      s3_nxt.pb_col = dec_wrap(s2_r.bc);
    end else if (s2_r.ac == s2_r.bc) begin
      s3_nxt.pa_row = dec_wrap(s2_r.ar);
      s3_nxt.pa_col = s2_r.ac;
      s3_nxt.pb_row = dec_wrap(s2_r.br);
      s3_nxt.pb_col = s2_r.bc;
    end else begin
      s3_nxt.pa_row = s2_r.ar;
      s3_nxt.pa_col = s2_r.bc;
      s3_nxt.pb_row = s2_r.br;
      s3_nxt.pb_col = s2_r.ac;
    end
  end

  // stage 4: cell read, zero when a letter was missing
  always_comb begin
    pa_nxt = s3_r.found ? cell_at(s3_r.pa_row, s3_r.pa_col) : '0;
    pb_nxt = s3_r.found ? cell_at(s3_r.pb_row, s3_r.pb_col) : '0;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= start & ~busy;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // payload stages, no reset needed
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    nf_r  <= ~s3_r.found;
    eot_r <= s3_r.eot;
  end

  assign out_strobe          = out_v_r;
  assign out_plain_a         = pa_r;
  assign out_plain_b         = pb_r;
  assign out_not_found       = nf_r;
  assign out_end_of_text_out = eot_r;

  // every accepted word comes out on out_strobe
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_strobe)
    else $error("accepted word lost in pipeline");

  // no strobe without a matching earlier start
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 4))
    else $error("result strobe without accepted word");

  // end-of-text mark follows its digraph
  a_eot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_end_of_text_out == $past(in_end_of_text, 4)))
    else $error("end-of-text mark out of step");

  // missing letter gives zero letters
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_not_found) |-> (out_plain_a == '0 && out_plain_b == '0))
    else $error("not_found result carries letters");

endmodule
